>>> sv/fdmb_pkg.sv
// fdmb_pkg: types and constants shared by the motion box block
// no dependencies
package fdmb_pkg;

	localparam int PixelW  = 8;
	localparam int CfgDimW = 13;
	localparam int CfgDataW = 13;
	localparam int CfgIdxW = 2;
	localparam int CoordW  = 16;
	localparam int BoxMaxW = 12;
	localparam int QueueDepth = 2;

	localparam logic [CoordW-1:0] NoMin = 16'hFFFF;

	localparam logic [CfgIdxW-1:0] CfgFrameWidth     = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgFrameHeight    = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgMotionThreshold = 2'd2;

	localparam logic [CfgDimW-1:0] ResetFrameWidth  = 13'd640;
	localparam logic [CfgDimW-1:0] ResetFrameHeight = 13'd480;
	localparam logic [PixelW-1:0]  ResetThreshold   = 8'd60;

	// one classified pixel passed from front to back
	typedef struct packed {
		logic [PixelW-1:0] diff;
		logic              motion;
		logic              frame_end;
		logic [CoordW-1:0] col;
		logic [CoordW-1:0] row;
	} fdmb_task_t;

	// handshake between front, queue and back
	typedef struct packed {
		logic       valid;
		fdmb_task_t task_data;
	} fdmb_push_t;

endpackage

>>> sv/fdmb_in_if.sv
// fdmb_in_if: input channel carrying a current / background pixel pair
// depends on fdmb_pkg
interface fdmb_in_if;
	logic                            valid;
	logic                            ready;
	logic [fdmb_pkg::PixelW-1:0]     current_pixel;
	logic [fdmb_pkg::PixelW-1:0]     background_pixel;

	modport source (output valid, output current_pixel, output background_pixel, input ready);
	modport sink (input valid, input current_pixel, input background_pixel, output ready);
endinterface

>>> sv/fdmb_out_if.sv
// fdmb_out_if: result channel carrying the difference pixel and frame box
// depends on fdmb_pkg
interface fdmb_out_if;
	logic                             valid;
	logic                             ready;
	logic [fdmb_pkg::PixelW-1:0]      difference_pixel;
	logic                             frame_end;
	logic                             motion_found;
	logic [fdmb_pkg::CoordW-1:0]      box_left;
	logic [fdmb_pkg::CoordW-1:0]      box_top;
	logic [fdmb_pkg::BoxMaxW-1:0]     box_right;
	logic [fdmb_pkg::BoxMaxW-1:0]     box_bottom;

	modport source (output valid, output difference_pixel, output frame_end,
		output motion_found, output box_left, output box_top, output box_right,
		output box_bottom, input ready);
	modport sink (input valid, input difference_pixel, input frame_end,
		input motion_found, input box_left, input box_top, input box_right,
		input box_bottom, output ready);
endinterface

>>> sv/fdmb_front.sv
// fdmb_front: accepts pixel pairs, computes difference, motion flag and raster position
// depends on fdmb_pkg, fdmb_in_if
module fdmb_front #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [fdmb_pkg::CfgDimW-1:0]    frame_width,
	input  logic [fdmb_pkg::CfgDimW-1:0]    frame_height,
	input  logic [fdmb_pkg::PixelW-1:0]     motion_threshold,
	fdmb_in_if.sink                         pixels,
	output fdmb_pkg::fdmb_push_t            push,
	input  logic                            push_ready
);
	localparam int CW = $clog2(MAX_DIMENSION);
	localparam int DW = 17;

	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic [CW-1:0] last_col;
	logic [CW-1:0] last_row;
	logic [fdmb_pkg::CfgDimW-1:0] w_m1;
	logic [fdmb_pkg::CfgDimW-1:0] h_m1;
	logic          row_end;
	logic          frame_end;
	logic          accept;
	logic [fdmb_pkg::PixelW-1:0] diff;
	logic          valid_s1;
	fdmb_pkg::fdmb_task_t task_s1;

	// effective last column / row: zero acts as one, oversize acts as the maximum
	always_comb begin
		w_m1 = frame_width - 13'd1;
		h_m1 = frame_height - 13'd1;
		if (frame_width == '0) begin
			last_col = '0;
		end else if (DW'(frame_width) > DW'(MAX_DIMENSION)) begin
			last_col = CW'(MAX_DIMENSION - 1);
		end else begin
			last_col = CW'(w_m1);
		end
		if (frame_height == '0) begin
			last_row = '0;
		end else if (DW'(frame_height) > DW'(MAX_DIMENSION)) begin
			last_row = CW'(MAX_DIMENSION - 1);
		end else begin
			last_row = CW'(h_m1);
		end
	end

	assign row_end   = (col_q >= last_col);
	assign frame_end = row_end && (row_q >= last_row);
	assign diff      = (pixels.current_pixel > pixels.background_pixel) ?
		(pixels.current_pixel - pixels.background_pixel) : '0;

	assign pixels.ready = !valid_s1 || push_ready;
	assign accept       = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (frame_end) begin
					col_q <= '0;
					row_q <= '0;
				end else if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			task_s1.diff      <= diff;
			task_s1.motion    <= (diff > motion_threshold);
			task_s1.frame_end <= frame_end;
			task_s1.col       <= fdmb_pkg::CoordW'(col_q);
			task_s1.row       <= fdmb_pkg::CoordW'(row_q);
		end
	end

	assign push.valid     = valid_s1;
	assign push.task_data = task_s1;
endmodule

>>> sv/fdmb_queue.sv
// fdmb_queue: short register queue that decouples front and back
// depends on fdmb_pkg
module fdmb_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fdmb_pkg::fdmb_push_t  push,
	output logic                  push_ready,
	output fdmb_pkg::fdmb_push_t  pop,
	input  logic                  pop_ready
);
	localparam int PW = $clog2(fdmb_pkg::QueueDepth);
	localparam int NW = $clog2(fdmb_pkg::QueueDepth + 1);

	fdmb_pkg::fdmb_task_t slot_q [fdmb_pkg::QueueDepth];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != NW'(fdmb_pkg::QueueDepth));
	assign do_push    = push.valid && push_ready;
	assign pop.valid  = (count_q != '0);
	assign pop.task_data = slot_q[rd_ptr_q];
	assign do_pop     = pop.valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(fdmb_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(fdmb_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.task_data;
		end
	end
endmodule

>>> sv/fdmb_back.sv
// fdmb_back: widens the motion box and registers one result beat per pixel
// depends on fdmb_pkg, fdmb_out_if
module fdmb_back #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fdmb_pkg::fdmb_push_t  pop,
	output logic                  pop_ready,
	fdmb_out_if.source            results
);
	localparam int CW = $clog2(MAX_DIMENSION);

	logic [fdmb_pkg::CoordW-1:0] min_col_q;
	logic [fdmb_pkg::CoordW-1:0] min_row_q;
	logic [CW-1:0]               max_col_q;
	logic [CW-1:0]               max_row_q;
	logic [fdmb_pkg::CoordW-1:0] new_min_col;
	logic [fdmb_pkg::CoordW-1:0] new_min_row;
	logic [CW-1:0]               new_max_col;
	logic [CW-1:0]               new_max_row;
	logic [fdmb_pkg::CoordW-1:0] max_col_ext;
	logic [fdmb_pkg::CoordW-1:0] max_row_ext;
	logic [CW-1:0]               x;
	logic [CW-1:0]               y;
	logic                        take;
	logic                        out_valid_q;
	fdmb_pkg::fdmb_task_t        t;

	logic [fdmb_pkg::PixelW-1:0] diff_q;
	logic                        frame_end_q;
	logic                        found_q;
	logic [fdmb_pkg::CoordW-1:0] left_q;
	logic [fdmb_pkg::CoordW-1:0] top_q;
	logic [fdmb_pkg::BoxMaxW-1:0] right_q;
	logic [fdmb_pkg::BoxMaxW-1:0] bottom_q;

	assign t         = pop.task_data;
	assign x         = CW'(t.col);
	assign y         = CW'(t.row);
	assign pop_ready = !out_valid_q || results.ready;
	assign take      = pop.valid && pop_ready;

	always_comb begin
		new_min_col = (t.motion && (t.col < min_col_q)) ? t.col : min_col_q;
		new_min_row = (t.motion && (t.row < min_row_q)) ? t.row : min_row_q;
		new_max_col = (t.motion && (x > max_col_q)) ? x : max_col_q;
		new_max_row = (t.motion && (y > max_row_q)) ? y : max_row_q;
		max_col_ext = fdmb_pkg::CoordW'(new_max_col);
		max_row_ext = fdmb_pkg::CoordW'(new_max_row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			min_col_q   <= fdmb_pkg::NoMin;
			min_row_q   <= fdmb_pkg::NoMin;
			max_col_q   <= '0;
			max_row_q   <= '0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				if (t.frame_end) begin
					min_col_q <= fdmb_pkg::NoMin;
					min_row_q <= fdmb_pkg::NoMin;
					max_col_q <= '0;
					max_row_q <= '0;
				end else begin
					min_col_q <= new_min_col;
					min_row_q <= new_min_row;
					max_col_q <= new_max_col;
					max_row_q <= new_max_row;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			diff_q      <= t.diff;
			frame_end_q <= t.frame_end;
			found_q     <= t.frame_end && (new_min_col != fdmb_pkg::NoMin);
			left_q      <= t.frame_end ? new_min_col : '0;
			top_q       <= t.frame_end ? new_min_row : '0;
			right_q     <= t.frame_end ? max_col_ext[fdmb_pkg::BoxMaxW-1:0] : '0;
			bottom_q    <= t.frame_end ? max_row_ext[fdmb_pkg::BoxMaxW-1:0] : '0;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.difference_pixel = diff_q;
	assign results.frame_end        = frame_end_q;
	assign results.motion_found     = found_q;
	assign results.box_left         = left_q;
	assign results.box_top          = top_q;
	assign results.box_right        = right_q;
	assign results.box_bottom       = bottom_q;
endmodule

>>> sv/frame_difference_motion_box.sv
// frame_difference_motion_box: top level, configuration registers and front/queue/back
// depends on fdmb_pkg, fdmb_in_if, fdmb_out_if, fdmb_front, fdmb_queue, fdmb_back
//
// usage
//  - pixels channel: one beat per pixel pair (current, background), raster order
//  - results channel: one beat per pixel beat, in order; difference_pixel is
//    current minus background clamped at zero; on the last pixel of a frame
//    frame_end is high and the box fields and motion_found describe the frame,
//    otherwise those fields are zero
//  - config port: cfg_we with cfg_index 0 = frame_width, 1 = frame_height,
//    2 = motion_threshold; other indexes are dropped; write only while idle
//  - path: a pixel beat passes the input register, a queue entry and the output
//    register before its result beat is valid
//  - throughput: one pixel per cycle sustained while results.ready stays high; the
//    front counters and the back box update once per beat
//  - stall: when results.ready is low the output register holds, the queue
//    fills, then the input register holds and pixels.ready drops; nothing lost
//  - reset: counters at column 0 row 0, box empty, registers 640 / 480 / 60
module frame_difference_motion_box #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fdmb_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [fdmb_pkg::CfgDataW-1:0]   cfg_data,
	fdmb_in_if.sink                         pixels,
	fdmb_out_if.source                      results
);
	// configuration registers
	logic [fdmb_pkg::CfgDimW-1:0] frame_width_q;
	logic [fdmb_pkg::CfgDimW-1:0] frame_height_q;
	logic [fdmb_pkg::PixelW-1:0]  threshold_q;

	// front to queue and queue to back
	fdmb_pkg::fdmb_push_t push;
	fdmb_pkg::fdmb_push_t pop;
	logic                 push_ready;
	logic                 pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= fdmb_pkg::ResetFrameWidth;
			frame_height_q <= fdmb_pkg::ResetFrameHeight;
			threshold_q    <= fdmb_pkg::ResetThreshold;
		end else if (cfg_we) begin
			case (cfg_index)
				fdmb_pkg::CfgFrameWidth:      frame_width_q  <= cfg_data;
				fdmb_pkg::CfgFrameHeight:     frame_height_q <= cfg_data;
				fdmb_pkg::CfgMotionThreshold: threshold_q    <= cfg_data[fdmb_pkg::PixelW-1:0];
				default: ;
			endcase
		end
	end

	// front: difference, motion flag, raster position
	fdmb_front #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.frame_width      (frame_width_q),
		.frame_height     (frame_height_q),
		.motion_threshold (threshold_q),
		.pixels           (pixels),
		.push             (push),
		.push_ready       (push_ready)
	);

	// queue: lets the front keep taking beats while the back stalls briefly
	fdmb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_ready  (pop_ready)
	);

	// back: box accumulation and result register
	fdmb_back #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.pop_ready (pop_ready),
		.results   (results)
	);
endmodule
